// ===== design/json_string_unescape_assert.svh =====
// Assertion macros shared by the unescaper modules.
// Define ASSERT_OFF to compile them out.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

`ifndef ASSERT_OFF
`define JSU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define JSU_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
`else
`define JSU_ASSERT(lbl, clk, rstn, prop)
`define JSU_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`endif

`endif

// ===== design/jsu_pkg.sv =====
`timescale 1ns / 1ps
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [15:0] CP_ONE_MAX = 16'h0080;
  localparam logic [15:0] CP_TWO_MAX = 16'h0800;

  localparam int unsigned MAX_BYTES = 4;

  // Up to four result bytes produced by one input byte.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] b;
    logic [2:0]                n;
  } bseq_t;

  // Queue entry: the byte group of one input byte plus its end flag.
  typedef struct packed {
    bseq_t seq;
    logic  last;
  } grp_t;

  typedef struct packed {
    logic       known;
    logic [7:0] val;
  } esc_t;

  // Nibble value, bit 4 set for a byte that is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] h);
    logic [4:0] v;
    if (h >= 8'h30 && h <= 8'h39)      v = 5'(h - 8'h30);
    else if (h >= 8'h61 && h <= 8'h66) v = 5'(h - 8'h57);
    else if (h >= 8'h41 && h <= 8'h46) v = 5'(h - 8'h37);
    else                               v = 5'h10;
    return v;
  endfunction

  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t e;
    e.known = 1'b1;
    unique case (c)
      CH_N:      e.val = 8'h0A;
      CH_T:      e.val = 8'h09;
      CH_R:      e.val = 8'h0D;
      CH_QUOTE:  e.val = CH_QUOTE;
      CH_BSLASH: e.val = CH_BSLASH;
      CH_SLASH:  e.val = CH_SLASH;
      CH_B:      e.val = 8'h08;
      CH_F:      e.val = 8'h0C;
      default: begin
        e.known = 1'b0;
        e.val   = c;
      end
    endcase
    return e;
  endfunction

  // Append a byte, drop it once four are held.
  function automatic bseq_t seq_push(input bseq_t s, input logic [7:0] x);
    bseq_t r;
    r = s;
    if (s.n < 3'(MAX_BYTES)) begin
      r.b[s.n[1:0]] = x;
      r.n = s.n + 3'd1;
    end
    return r;
  endfunction

  function automatic bseq_t utf8_enc(input logic [15:0] cp);
    bseq_t r;
    r = '0;
    if (cp < CP_ONE_MAX) begin
      r.b[0] = cp[7:0];
      r.n    = 3'd1;
    end else if (cp < CP_TWO_MAX) begin
      r.b[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      r.b[1] = UTF8_CONT | {2'b00, cp[5:0]};
      r.n    = 3'd2;
    end else begin
      r.b[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      r.b[1] = UTF8_CONT | {2'b00, cp[11:6]};
      r.b[2] = UTF8_CONT | {2'b00, cp[5:0]};
      r.n    = 3'd3;
    end
    return r;
  endfunction

endpackage

// ===== design/jsu_fifo.sv =====
`timescale 1ns / 1ps
`include "json_string_unescape_assert.svh"
module jsu_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::grp_t push_data,
  output logic          full,
  input  logic          pop,
  output jsu_pkg::grp_t head,
  output logic          empty
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  `JSU_ASSERT_MSG(a_no_overflow, clk, rst_n, push |-> !full, "queue overflow")
  `JSU_ASSERT_MSG(a_no_underflow, clk, rst_n, pop |-> !empty, "queue underflow")

endmodule

// ===== design/jsu_front.sv =====
`timescale 1ns / 1ps
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          q_full,
  output logic          q_push,
  output jsu_pkg::grp_t q_data
);
  import jsu_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [1:0]       hcnt_r, hcnt_nxt;
  logic [2:0][7:0]  held_r, held_nxt;
  logic             accept;
  grp_t             grp;
  esc_t             esc;
  logic [4:0]       nib0, nib1, nib2, nib3;
  logic             bad_hex;
  logic [15:0]      cp;

  // Replay the held digit bytes as plain input once the string ends
  // inside a \u escape. Three bytes nest at most one more \u.
  function automatic bseq_t replay_held(input logic [2:0][7:0] h, input logic [1:0] n);
    bseq_t           acc;
    logic [2:0][7:0] src;
    logic [2:0][7:0] nh;
    logic [1:0]      sn;
    logic [1:0]      c;
    mode_t           m;
    esc_t            e;
    logic [7:0]      x;
    acc = '0;
    src = h;
    nh  = h;
    sn  = n;
    c   = 2'd0;
    m   = MODE_HEX;
    for (int r = 0; r < 2; r++) begin
      if (m == MODE_HEX) begin
        acc = seq_push(acc, CH_U);
        m   = MODE_NORMAL;
        c   = 2'd0;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < sn) begin
            x = src[k];
            e = esc_map(x);
            unique case (m)
              MODE_ESC: begin
                m = MODE_NORMAL;
                if (x == CH_U) begin
                  m = MODE_HEX;
                  c = 2'd0;
                end else if (e.known) begin
                  acc = seq_push(acc, e.val);
                end else begin
                  acc = seq_push(acc, CH_BSLASH);
                  acc = seq_push(acc, x);
                end
              end
              MODE_HEX: begin
                if (c != 2'd3) begin
                  nh[c] = x;
                  c     = c + 2'd1;
                end
              end
              default: begin
                if (x == CH_BSLASH) m = MODE_ESC;
                else                acc = seq_push(acc, x);
              end
            endcase
          end
        end
        src = nh;
        sn  = c;
      end
    end
    return acc;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign nib0    = hex_val(held_r[0]);
  assign nib1    = hex_val(held_r[1]);
  assign nib2    = hex_val(held_r[2]);
  assign nib3    = hex_val(in_byte);
  assign bad_hex = nib0[4] | nib1[4] | nib2[4] | nib3[4];
  assign cp      = bad_hex ? 16'h0000 : {nib0[3:0], nib1[3:0], nib2[3:0], nib3[3:0]};
  assign esc     = esc_map(in_byte);

  always_comb begin
    grp      = '0;
    grp.last = in_last;
    mode_nxt = mode_r;
    hcnt_nxt = hcnt_r;
    held_nxt = held_r;
    unique case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_NORMAL;
        if (in_byte == CH_U) begin
          mode_nxt = MODE_HEX;
          hcnt_nxt = 2'd0;
        end else if (esc.known) begin
          grp.seq = seq_push(grp.seq, esc.val);
        end else begin
          grp.seq = seq_push(grp.seq, CH_BSLASH);
          grp.seq = seq_push(grp.seq, in_byte);
        end
      end
      MODE_HEX: begin
        if (hcnt_r != 2'd3) begin
          held_nxt[hcnt_r] = in_byte;
          hcnt_nxt         = hcnt_r + 2'd1;
        end else begin
          grp.seq  = utf8_enc(cp);
          mode_nxt = MODE_NORMAL;
          hcnt_nxt = 2'd0;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (in_byte == CH_BSLASH) mode_nxt = MODE_ESC;
        else                      grp.seq  = seq_push(grp.seq, in_byte);
      end
    endcase
    if (in_last) begin
      // an open \u emits nothing on this byte, so the replay starts empty
      if (mode_nxt == MODE_HEX) grp.seq = replay_held(held_nxt, hcnt_nxt);
      mode_nxt = MODE_NORMAL;
      hcnt_nxt = 2'd0;
    end
  end

  // drop groups without bytes unless they close the string
  assign q_push = accept && ((grp.seq.n != 3'd0) || grp.last);
  assign q_data = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      hcnt_r <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_r <= held_nxt;
  end

endmodule

// ===== design/jsu_back.sv =====
`timescale 1ns / 1ps
`include "json_string_unescape_assert.svh"
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::grp_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_last
);
  import jsu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_bv_r;
  logic       out_last_r;
  logic       load;
  logic [2:0] nitems;
  logic       final_item;
  logic       marker;

  assign marker     = (q_head.seq.n == 3'd0);
  assign nitems     = marker ? 3'd1 : q_head.seq.n;
  assign final_item = (({1'b0, idx_r} + 3'd1) == nitems);
  assign load       = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop      = load && final_item;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = final_item ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= marker ? 8'h00 : q_head.seq.b[idx_r];
      out_bv_r   <= !marker;
      out_last_r <= q_head.last && final_item;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_last       = out_last_r;

  `JSU_ASSERT(a_idx_needs_head, clk, rst_n, (idx_r != 2'd0) |-> !q_empty)
  `JSU_ASSERT(a_marker_is_last, clk, rst_n, (out_valid_r && !out_bv_r) |-> out_last_r)

endmodule

// ===== design/json_string_unescape.sv =====
`timescale 1ns / 1ps
// JSON string body unescaper.
// Input channel (in_valid / in_stall): one raw byte of the escaped string
// per transfer, in_last on the final byte of the string.
// Output channel (out_valid / out_stall): one unescaped byte per transfer,
// UTF-8 for \u code points. out_last marks the final result of a string;
// a string end that yields no byte gives one transfer with
// out_byte_valid low and out_byte zero.
// The front stage decodes escapes and writes the up to four bytes of each
// input byte as one entry into a small queue; the back stage drains that
// queue one byte per cycle into the output register while out_stall is low.
// Between an input transfer and out_valid lie the queue entry and the output
// register. Throughput: one input byte per cycle while each yields at most
// one output byte and the output is not stalled; the single output port sets
// the rate, so an input that yields several bytes holds the output for one
// transfer per byte and the queue fills.
// Reset (synchronous, rst_n low) returns to normal byte mode and empties
// the queue. A stalled output holds its byte; input stalls only when the
// queue is full.
module json_string_unescape #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last
);
  import jsu_pkg::*;

  grp_t q_in;
  grp_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 120;
  localparam int REPORT_MAX   = 10;

  localparam logic [7:0] LF  = 8'h0A;
  localparam logic [7:0] TAB = 8'h09;
  localparam logic [7:0] CR  = 8'h0D;
  localparam logic [7:0] BS  = 8'h08;
  localparam logic [7:0] FF  = 8'h0C;

  localparam logic [7:0] KNOWN_ESC [8] = '{CH_N, CH_T, CH_R, CH_QUOTE,
                                           CH_BSLASH, CH_SLASH, CH_B, CH_F};

  typedef struct packed {
    logic [7:0] value;
    logic       real_byte;
    logic       ends;
  } out_char_t;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last;

  json_string_unescape i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Unescaper state as seen from the stream.
  mode_t      parse_state = MODE_NORMAL;
  logic [2:0] hex_seen    = 3'd0;
  logic [7:0] held_digits [4];

  out_char_t step_chars[$];
  out_char_t pending_chars[$];

  int items_sent    = 0;
  int fail_count    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_count    = 0;

  function automatic logic [4:0] nibble_of(input logic [7:0] h);
    if (h >= "0" && h <= "9") return {1'b0, 4'(h - "0")};
    if (h >= "a" && h <= "f") return {1'b0, 4'(h - "a" + 10)};
    if (h >= "A" && h <= "F") return {1'b0, 4'(h - "A" + 10)};
    return 5'h10;
  endfunction

  function automatic void push_char(input logic [7:0] c);
    // One input byte never yields more than four results; drop the rest.
    if (step_chars.size() < MAX_BYTES) step_chars.push_back('{c, 1'b1, 1'b0});
  endfunction

  function automatic void push_code_point(input logic [15:0] cp);
    if (cp < CP_ONE_MAX) begin
      push_char(cp[7:0]);
    end else if (cp < CP_TWO_MAX) begin
      push_char(UTF8_LEAD2 | {3'b000, cp[10:6]});
      push_char(UTF8_CONT | {2'b00, cp[5:0]});
    end else begin
      push_char(UTF8_LEAD3 | {4'b0000, cp[15:12]});
      push_char(UTF8_CONT | {2'b00, cp[11:6]});
      push_char(UTF8_CONT | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void unescape_byte(input logic [7:0] b);
    logic [15:0] cp;
    logic [4:0]  nib;
    logic        all_hex;
    int          k;
    if (parse_state == MODE_ESC) begin
      parse_state = MODE_NORMAL;
      case (b)
        CH_N:      push_char(LF);
        CH_T:      push_char(TAB);
        CH_R:      push_char(CR);
        CH_QUOTE:  push_char(CH_QUOTE);
        CH_BSLASH: push_char(CH_BSLASH);
        CH_SLASH:  push_char(CH_SLASH);
        CH_B:      push_char(BS);
        CH_F:      push_char(FF);
        CH_U: begin
          parse_state = MODE_HEX;
          hex_seen    = 3'd0;
        end
        default: begin
          push_char(CH_BSLASH);
          push_char(b);
        end
      endcase
    end else if (parse_state == MODE_HEX) begin
      if (hex_seen < 3'd3) begin
        held_digits[hex_seen[1:0]] = b;
        hex_seen = hex_seen + 3'd1;
      end else begin
        cp      = 16'h0000;
        all_hex = 1'b1;
        for (k = 0; k < 4; k++) begin
          nib = nibble_of(k < 3 ? held_digits[k] : b);
          if (nib[4]) all_hex = 1'b0;
          cp = {cp[11:0], nib[3:0]};
        end
        if (!all_hex) cp = 16'h0000;
        parse_state = MODE_NORMAL;
        hex_seen    = 3'd0;
        push_code_point(cp);
      end
    end else begin
      if (b == CH_BSLASH) parse_state = MODE_ESC;
      else begin
        parse_state = MODE_NORMAL;
        push_char(b);
      end
    end
  endfunction

  // String ended inside \u: give 'u' and run the held digits through again.
  function automatic void close_string();
    logic [7:0] replay [3];
    int         n;
    int         k;
    while (parse_state == MODE_HEX) begin
      n = (hex_seen > 3'd3) ? 3 : int'(hex_seen);
      for (k = 0; k < n; k++) replay[k] = held_digits[k];
      parse_state = MODE_NORMAL;
      hex_seen    = 3'd0;
      push_char(CH_U);
      for (k = 0; k < n; k++) unescape_byte(replay[k]);
    end
    parse_state = MODE_NORMAL;
    hex_seen    = 3'd0;
  endfunction

  function automatic void predict_transfer(input logic [7:0] b, input logic last);
    int idx;
    step_chars.delete();
    unescape_byte(b);
    if (last) begin
      close_string();
      if (step_chars.size() == 0) step_chars.push_back('{8'h00, 1'b0, 1'b1});
      else begin
        idx = step_chars.size() - 1;
        step_chars[idx].ends = 1'b1;
      end
    end
    foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
  endfunction

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_transfer(b, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic send_str(input string s);
    logic [7:0] text[$];
    foreach (s[i]) text.push_back(s[i]);
    send_text(text);
  endtask

  // Drop valid so the last byte is not offered again, then wait out the results.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_chars.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(1) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic void append_hex(ref logic [7:0] text[$], input logic [15:0] cp);
    text.push_back(hex_char(cp[15:12]));
    text.push_back(hex_char(cp[11:8]));
    text.push_back(hex_char(cp[7:4]));
    text.push_back(hex_char(cp[3:0]));
  endfunction

  task automatic send_random_string();
    logic [7:0]  text[$];
    logic [7:0]  junk;
    logic [15:0] cp;
    int          tokens;
    int          pick;
    int          pos;
    int          k;
    if ($urandom_range(9) == 0) begin
      // Noise: raw bytes with string ends anywhere.
      tokens = $urandom_range(1, 5);
      for (k = 0; k < tokens; k++)
        send_byte(8'($urandom_range(255)),
                  (k == tokens - 1) || ($urandom_range(3) == 0));
      return;
    end
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        text.push_back(8'($urandom_range(255)));
      end else if (pick < 55) begin
        text.push_back(CH_BSLASH);
        text.push_back(KNOWN_ESC[3'($urandom_range(7))]);
      end else if (pick < 62) begin
        text.push_back(CH_BSLASH);
        text.push_back(8'($urandom_range(255)));
      end else if (pick < 88) begin
        case ($urandom_range(2))
          0:       cp = 16'($urandom_range(16'h007F));
          1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
          default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        endcase
        text.push_back(CH_BSLASH);
        text.push_back(CH_U);
        append_hex(text, cp);
      end else begin
        text.push_back(CH_BSLASH);
        text.push_back(CH_U);
        append_hex(text, 16'($urandom_range(16'hFFFF)));
        pos  = text.size() - 1 - $urandom_range(3);
        junk = 8'($urandom_range(255));
        while (nibble_of(junk) < 5'h10) junk = 8'($urandom_range(255));
        text[pos] = junk;
      end
    end
    pick = $urandom_range(9);
    if (pick < 2) begin
      // Cut the string inside \u, digits drawn from a mix that replays oddly.
      text.push_back(CH_BSLASH);
      text.push_back(CH_U);
      repeat ($urandom_range(3)) begin
        case ($urandom_range(3))
          0:       text.push_back(hex_char(4'($urandom_range(15))));
          1:       text.push_back(CH_BSLASH);
          2:       text.push_back(CH_U);
          default: text.push_back(8'($urandom_range(255)));
        endcase
      end
    end else if (pick == 2) begin
      text.push_back(CH_BSLASH);
    end
    send_text(text);
  endtask

  task automatic test_byte_extremes();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_escapes();
    send_str("\\n\\\"\\f\\q");
  endtask

  task automatic test_code_points();
    send_str("\\u07fF\\uFfFf");
    send_str("\\u12G4");
  endtask

  task automatic test_string_end_cases();
    send_str("\\u1");
    send_str("\\");
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (8) send_str("\\uFFFF");
    wait_drained();
  endtask

  task automatic test_random_strings(input int send_pct, input int recv_pct,
                                     input int count);
    int goal;
    goal          = items_sent + count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (items_sent < goal) send_random_string();
  endtask

  // Result receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      if (hold_count < LONG_HOLD) begin
        out_stall  <= 1'b1;
        hold_count <= hold_count + 1;
      end else begin
        out_stall    <= 1'b0;
        hold_count   <= 0;
        holds_served <= holds_served + 1;
      end
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected transfer: byte %02h valid %0b last %0b",
                   out_byte, out_byte_valid, out_last);
      end else begin
        want = pending_chars.pop_front();
        if (out_byte !== want.value || out_byte_valid !== want.real_byte ||
            out_last !== want.ends) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: expected byte %02h valid %0b last %0b, got %02h %0b %0b",
                     want.value, want.real_byte, want.ends,
                     out_byte, out_byte_valid, out_last);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_byte_extremes();
    test_escapes();
    test_code_points();
    test_string_end_cases();
    test_output_backpressure();
    test_random_strings(29, 87, 75);
    test_random_strings(87, 29, 75);
    test_random_strings(0, 0, 75);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
